// File: hw/rtl/ray_segment_nearest_hit_assert.svh
// ----------------------------------------------------------------------------
// Ray segment nearest hit: assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RAY_SEGMENT_NEAREST_HIT_ASSERT_SVH
`define RAY_SEGMENT_NEAREST_HIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RSNH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define RSNH_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define RSNH_ASSERT(lbl, clk, rst, prop)
`define RSNH_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: hw/rtl/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// Ray segment nearest hit: package
// Widths, table size and the control word of the shared multiply-accumulate.
// ----------------------------------------------------------------------------
package rsnh_pkg;
   localparam int ENTRIES = 1024;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int COORD_W = 13;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MA_W    = 30;
   localparam int MB_W    = 15;
   localparam int ACC_W   = 46;
   localparam int MAG_W   = ACC_W - 1;
   localparam int Q_W     = 13;
   localparam int STEP_W  = 4;
   localparam int ENTRY_W = 4 * COORD_W;

   typedef struct packed {
      logic clear;
      logic sub;
   } mac_ctl_type;
endpackage

// File: hw/rtl/rsnh_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate
// One signed product per cycle, added to or subtracted from the accumulator or, on clear, zero.
// ----------------------------------------------------------------------------
module rsnh_mac import rsnh_pkg::*; (
   input  logic                    clock,
   input  logic signed [MA_W-1:0]  op_a,
   input  logic signed [MB_W-1:0]  op_b,
   input  mac_ctl_type             ctl,
   output logic signed [ACC_W-1:0] acc
);
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] prod;

   always_comb begin
      prod   = ACC_W'(op_a * op_b);
      acc_in = (ctl.clear ? '0 : acc_ff) + (ctl.sub ? -prod : prod);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// File: hw/rtl/rsnh_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Signed dividend over positive divisor, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`include "ray_segment_nearest_hit_assert.svh"
module rsnh_div import rsnh_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] dividend,
   input  logic        [MA_W-1:0]  divisor,
   output logic                    done,
   output logic signed [Q_W-1:0]   quotient
);
   logic [MAG_W-1:0]  rem_ff, rem_in, sh_ff, sh_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [ACC_W-1:0]  mag;

   always_comb begin
      mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = mag[MAG_W-1:0];
         sh_in   = MAG_W'(divisor) << (Q_W - 1);
         q_in    = '0;
         cnt_in  = STEP_W'(Q_W - 1);
         neg_in  = dividend[ACC_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= sh_ff) begin
            rem_in = rem_ff - sh_ff;
            q_in   = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[Q_W-2:0], 1'b0};
         end
         sh_in  = sh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

   `RSNH_ASSERT(a_div_start_busy, clock, reset, start |=> busy_ff)
   `RSNH_ASSERT(a_div_done_pulse, clock, reset, done_ff |=> !done_ff)
   `RSNH_NEVER(a_div_done_while_busy, clock, reset, done_ff && busy_ff)
endmodule

// File: hw/rtl/ray_segment_nearest_hit.sv
// A cast's duration grows with each table entry, and more with each entry that is hit,
// set by the single shared multiplier (6 products per entry) and the divider.
// A write does not raise busy.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: synchronous; a clearing pass over all ENTRIES entries follows with busy high.
// Results cannot be stalled: rsp_valid lasts one cycle.
// ----------------------------------------------------------------------------
// Ray segment nearest hit: top level
// Segment table, sequencer, shared multiply-accumulate and divider.
// ----------------------------------------------------------------------------
`include "ray_segment_nearest_hit_assert.svh"
module ray_segment_nearest_hit import rsnh_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_cmd,
   input  logic [9:0]                req_entry_index,
   input  logic signed [COORD_W-1:0] req_ax,
   input  logic signed [COORD_W-1:0] req_ay,
   input  logic signed [COORD_W-1:0] req_bx,
   input  logic signed [COORD_W-1:0] req_by,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic signed [COORD_W-1:0] rsp_hit_x,
   output logic signed [COORD_W-1:0] rsp_hit_y
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_CLR = 5'd1,  S_RD  = 5'd2,  S_M0  = 5'd3,
                          S_M1   = 5'd4,  S_M2  = 5'd5,  S_M3  = 5'd6,  S_M4  = 5'd7,
                          S_M5   = 5'd8,  S_CHK = 5'd9,  S_NX0 = 5'd10, S_NX1 = 5'd11,
                          S_DXS  = 5'd12, S_DXW = 5'd13, S_NY0 = 5'd14, S_NY1 = 5'd15,
                          S_DYS  = 5'd16, S_DYW = 5'd17, S_D0  = 5'd18, S_D1  = 5'd19,
                          S_CMP  = 5'd20, S_NEXT = 5'd21, S_OUT = 5'd22;

   logic [4:0]  state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [ENTRY_W-1:0] mem [ENTRIES];
   logic [ENTRY_W-1:0] mem_q_ff;
   logic               we;
   logic [IDX_W-1:0]   waddr;
   logic [ENTRY_W-1:0] wdata;

   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [COORD_W-1:0] x1, y1, x2, y2;
   logic signed [DIFF_W-1:0]  d12x, d12y, d13x, d13y, r34x, r34y, sx, sy, dx, dy;
   logic signed [MA_W-1:0]    den_ff, den_in, tn_ff, tn_in, un;
   logic signed [MA_W-1:0]    den_n, tn_n, un_n;
   logic                      entry_hit;
   logic signed [COORD_W-1:0] hx_ff, hx_in, hy_ff, hy_in, bestx_ff, bestx_in;
   logic signed [COORD_W-1:0] besty_ff, besty_in;
   logic [MA_W-1:0]           bestd_ff, bestd_in, sq_dist;
   logic                      found_ff, found_in;
   logic                      accept, wr_ok;

   logic signed [MA_W-1:0]    mac_a;
   logic signed [MB_W-1:0]    mac_b;
   mac_ctl_type               mac_ctl;
   logic signed [ACC_W-1:0]   acc;
   logic                      div_start, div_done;
   logic signed [Q_W-1:0]     quo;

   logic rsp_valid_ff, rsp_valid_in, rsp_hit_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;

   rsnh_mac u_mac (
      .clock (clock),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   rsnh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign accept = start && !busy;
   assign wr_ok  = {1'b0, req_entry_index} < 11'(ENTRIES);

   always_comb begin
      {x1, y1, x2, y2} = mem_q_ff;
      d12x = DIFF_W'(x1) - DIFF_W'(x2);
      d12y = DIFF_W'(y1) - DIFF_W'(y2);
      d13x = DIFF_W'(x1) - DIFF_W'(ax_ff);
      d13y = DIFF_W'(y1) - DIFF_W'(ay_ff);
      r34x = DIFF_W'(ax_ff) - DIFF_W'(bx_ff);
      r34y = DIFF_W'(ay_ff) - DIFF_W'(by_ff);
      sx   = DIFF_W'(x2) - DIFF_W'(x1);
      sy   = DIFF_W'(y2) - DIFF_W'(y1);
      dx   = DIFF_W'(hx_ff) - DIFF_W'(ax_ff);
      dy   = DIFF_W'(hy_ff) - DIFF_W'(ay_ff);
      un   = -acc[MA_W-1:0];
      // flip all three so the denominator is positive
      den_n = den_ff[MA_W-1] ? -den_ff : den_ff;
      tn_n  = den_ff[MA_W-1] ? -tn_ff  : tn_ff;
      un_n  = den_ff[MA_W-1] ? -un     : un;
      entry_hit = (den_ff != '0) && (tn_n > 0) && (tn_n < den_n) && (un_n > 0);
      sq_dist = acc[MA_W-1:0];
   end

   always_comb begin
      mac_a   = '0;
      mac_b   = '0;
      mac_ctl = '{clear: 1'b0, sub: 1'b0};
      case (state_ff)
         S_M0:  begin mac_a = MA_W'(d12x); mac_b = MB_W'(r34y); mac_ctl.clear = 1'b1; end
         S_M1:  begin mac_a = MA_W'(d12y); mac_b = MB_W'(r34x); mac_ctl.sub = 1'b1; end
         S_M2:  begin mac_a = MA_W'(d13x); mac_b = MB_W'(r34y); mac_ctl.clear = 1'b1; end
         S_M3:  begin mac_a = MA_W'(d13y); mac_b = MB_W'(r34x); mac_ctl.sub = 1'b1; end
         S_M4:  begin mac_a = MA_W'(d12x); mac_b = MB_W'(d13y); mac_ctl.clear = 1'b1; end
         S_M5:  begin mac_a = MA_W'(d12y); mac_b = MB_W'(d13x); mac_ctl.sub = 1'b1; end
         S_NX0: begin mac_a = den_ff; mac_b = MB_W'(x1); mac_ctl.clear = 1'b1; end
         S_NX1: begin mac_a = tn_ff; mac_b = MB_W'(sx); end
         S_NY0: begin mac_a = den_ff; mac_b = MB_W'(y1); mac_ctl.clear = 1'b1; end
         S_NY1: begin mac_a = tn_ff; mac_b = MB_W'(sy); end
         S_D0:  begin mac_a = MA_W'(dx); mac_b = MB_W'(dx); mac_ctl.clear = 1'b1; end
         S_D1:  begin mac_a = MA_W'(dy); mac_b = MB_W'(dy); end
         default: begin end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      den_in       = den_ff;
      tn_in        = tn_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      bestx_in     = bestx_ff;
      besty_in     = besty_ff;
      bestd_in     = bestd_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      div_start    = 1'b0;
      we           = 1'b0;
      waddr        = req_entry_index[IDX_W-1:0];
      wdata        = {req_ax, req_ay, req_bx, req_by};
      case (state_ff)
         S_IDLE: begin
            if (accept && !req_cmd) begin
               we = wr_ok;
            end else if (accept) begin
               k_in     = '0;
               found_in = 1'b0;
               bestx_in = '0;
               besty_in = '0;
               bestd_in = '0;
               state_in = S_RD;
            end
         end
         S_CLR: begin
            we    = 1'b1;
            waddr = k_ff[IDX_W-1:0];
            wdata = '0;
            k_in  = k_ff + 1'b1;
            if (k_ff == CNT_W'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_RD:  state_in = S_M0;
         S_M0:  state_in = S_M1;
         S_M1:  state_in = S_M2;
         S_M2:  begin den_in = acc[MA_W-1:0]; state_in = S_M3; end
         S_M3:  state_in = S_M4;
         S_M4:  begin tn_in = acc[MA_W-1:0]; state_in = S_M5; end
         S_M5:  state_in = S_CHK;
         S_CHK: begin
            den_in   = den_n;
            tn_in    = tn_n;
            state_in = entry_hit ? S_NX0 : S_NEXT;
         end
         S_NX0: state_in = S_NX1;
         S_NX1: state_in = S_DXS;
         S_DXS: begin div_start = 1'b1; state_in = S_DXW; end
         S_DXW: begin
            if (div_done) begin
               hx_in    = quo;
               state_in = S_NY0;
            end
         end
         S_NY0: state_in = S_NY1;
         S_NY1: state_in = S_DYS;
         S_DYS: begin div_start = 1'b1; state_in = S_DYW; end
         S_DYW: begin
            if (div_done) begin
               hy_in    = quo;
               state_in = S_D0;
            end
         end
         S_D0:  state_in = S_D1;
         S_D1:  state_in = S_CMP;
         S_CMP: begin
            // strict compare: the lowest index keeps a tie
            if (!found_ff || sq_dist < bestd_ff) begin
               found_in = 1'b1;
               bestd_in = sq_dist;
               bestx_in = hx_ff;
               besty_in = hy_ff;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            k_in     = k_ff + 1'b1;
            state_in = (k_ff == CNT_W'(ENTRIES - 1)) ? S_OUT : S_RD;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      mem_q_ff <= mem[k_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      den_ff   <= den_in;
      tn_ff    <= tn_in;
      hx_ff    <= hx_in;
      hy_ff    <= hy_in;
      bestx_ff <= bestx_in;
      besty_ff <= besty_in;
      bestd_ff <= bestd_in;
      if (accept && req_cmd) begin
         ax_ff <= req_ax;
         ay_ff <= req_ay;
         bx_ff <= req_bx;
         by_ff <= req_by;
      end
      if (state_ff == S_OUT) begin
         rsp_hit_ff <= found_ff;
         rsp_x_ff   <= bestx_ff;
         rsp_y_ff   <= besty_ff;
      end
      if (reset) begin
         state_ff     <= S_CLR;
         k_ff         <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_x = rsp_x_ff;
   assign rsp_hit_y = rsp_y_ff;

   `RSNH_ASSERT(a_rsp_single, clock, reset, rsp_valid_ff |=> !rsp_valid_ff)
   `RSNH_ASSERT(a_rsp_idle, clock, reset, rsp_valid_ff |-> !busy)
   `RSNH_NEVER(a_nohit_zero, clock, reset,
      rsp_valid_ff && !rsp_hit_ff && (rsp_x_ff != '0 || rsp_y_ff != '0))
   `RSNH_ASSERT(a_write_quiet, clock, reset, (accept && !req_cmd) |=> !rsp_valid_ff)
endmodule

// File: verif/rsnh_tb_pkg.sv
// ----------------------------------------------------------------------------
// Ray segment nearest hit: testbench package
// Command codes and the result word shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package rsnh_tb_pkg;
   import rsnh_pkg::*;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_CAST  = 1'b1
   } cmd_type;

   typedef struct {
      logic                      hit;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } hit_word_type;
endpackage

// File: verif/rsnh_checker.sv
// ----------------------------------------------------------------------------
// Ray segment nearest hit: checker
// Mirrors the wall table from accepted writes, computes the nearest hit of
// each accepted cast and compares it with the result strobe.
// ----------------------------------------------------------------------------
module rsnh_checker import rsnh_pkg::*, rsnh_tb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_cmd,
   input  logic [9:0]                req_entry_index,
   input  logic signed [COORD_W-1:0] req_ax,
   input  logic signed [COORD_W-1:0] req_ay,
   input  logic signed [COORD_W-1:0] req_bx,
   input  logic signed [COORD_W-1:0] req_by,
   input  logic                      rsp_valid,
   input  logic                      rsp_hit,
   input  logic signed [COORD_W-1:0] rsp_hit_x,
   input  logic signed [COORD_W-1:0] rsp_hit_y,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   longint wall_x1 [ENTRIES];
   longint wall_y1 [ENTRIES];
   longint wall_x2 [ENTRIES];
   longint wall_y2 [ENTRIES];
   hit_word_type hits_due [$];

   function automatic hit_word_type nearest_hit(longint x3, longint y3,
                                                longint x4, longint y4);
      hit_word_type w;
      longint x1, y1, x2, y2, den, tn, un, hx, hy, d, best;
      w.hit = 1'b0;
      w.x   = '0;
      w.y   = '0;
      best  = 0;
      for (int k = 0; k < ENTRIES; k++) begin
         x1  = wall_x1[k];
         y1  = wall_y1[k];
         x2  = wall_x2[k];
         y2  = wall_y2[k];
         den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
         if (den == 0) continue;
         tn = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
         un = -((x1 - x2) * (y1 - y3) - (y1 - y2) * (x1 - x3));
         if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
         end
         if (!(tn > 0 && tn < den && un > 0)) continue;
         hx = (x1 * den + tn * (x2 - x1)) / den;
         hy = (y1 * den + tn * (y2 - y1)) / den;
         d  = (hx - x3) * (hx - x3) + (hy - y3) * (hy - y3);
         // strict compare: lowest index keeps a tie
         if (!w.hit || d < best) begin
            w.hit = 1'b1;
            best  = d;
            w.x   = hx[COORD_W-1:0];
            w.y   = hy[COORD_W-1:0];
         end
      end
      return w;
   endfunction

   assign pending = hits_due.size();

   always @(posedge clock) begin
      hit_word_type want;
      if (reset) begin
         fail_count <= 0;
         hits_due.delete();
         for (int k = 0; k < ENTRIES; k++) begin
            wall_x1[k] = 0;
            wall_y1[k] = 0;
            wall_x2[k] = 0;
            wall_y2[k] = 0;
         end
      end else begin
         if (rsp_valid) begin
            if (hits_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word: hit=%0d x=%0d y=%0d",
                           rsp_hit, rsp_hit_x, rsp_hit_y);
               fail_count <= fail_count + 1;
            end else begin
               want = hits_due.pop_front();
               if (rsp_hit !== want.hit || rsp_hit_x !== want.x || rsp_hit_y !== want.y) begin
                  if (fail_count < 10)
                     $display("hit mismatch: expected %0d (%0d,%0d) got %0d (%0d,%0d)",
                              want.hit, want.x, want.y, rsp_hit, rsp_hit_x, rsp_hit_y);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            if (cmd_type'(req_cmd) == CMD_CAST) begin
               hits_due.push_back(nearest_hit(req_ax, req_ay, req_bx, req_by));
            end else if (req_entry_index < ENTRIES) begin
               wall_x1[req_entry_index] = req_ax;
               wall_y1[req_entry_index] = req_ay;
               wall_x2[req_entry_index] = req_bx;
               wall_y2[req_entry_index] = req_by;
            end
         end
      end
   end
endmodule

// File: verif/tb_ray_segment_nearest_hit.sv
// ----------------------------------------------------------------------------
// Ray segment nearest hit: testbench top
// Directed walls and casts for axis hits, parallel walls, endpoints, ties and
// erased walls, then random writes and casts, mostly with idle gaps on the sender.
// ----------------------------------------------------------------------------
module tb_ray_segment_nearest_hit;
   import rsnh_pkg::*;
   import rsnh_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_cmd = CMD_WRITE;
   logic [9:0]                req_entry_index = '0;
   logic signed [COORD_W-1:0] req_ax = '0;
   logic signed [COORD_W-1:0] req_ay = '0;
   logic signed [COORD_W-1:0] req_bx = '0;
   logic signed [COORD_W-1:0] req_by = '0;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic signed [COORD_W-1:0] rsp_hit_x;
   logic signed [COORD_W-1:0] rsp_hit_y;
   int                        fail_count;
   int                        pending;
   bit                        gaps_on = 1'b1;

   always #1 clock = ~clock;

   ray_segment_nearest_hit u_top (.*);

   rsnh_checker u_checker (.*);

   task automatic send_word(cmd_type cmd, int idx, int ax, int ay, int bx, int by);
      // hold start low while busy or on a random gap
      while (busy || (gaps_on && $urandom_range(99) < 12)) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_entry_index <= idx[9:0];
      req_ax          <= ax[COORD_W-1:0];
      req_ay          <= ay[COORD_W-1:0];
      req_bx          <= bx[COORD_W-1:0];
      req_by          <= by[COORD_W-1:0];
      @(negedge clock);
   endtask

   function automatic int pick_coord(bit near);
      if (near) return $urandom_range(128) - 64;
      return $urandom_range(8191) - 4096;
   endfunction

   initial begin
      int  sel;
      bit  near;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(CMD_CAST, 0, 0, -100, 0, 100);               // empty table
      send_word(CMD_WRITE, 0, -4096, 0, 4095, 0);
      send_word(CMD_CAST, 0, 0, -100, 0, 100);               // hit on the origin
      send_word(CMD_WRITE, 1023, 100, -4096, 100, 4095);
      send_word(CMD_CAST, 1023, -50, -50, -50, 50);          // parallel wall skipped
      send_word(CMD_CAST, 0, -4096, 7, 4095, 7);             // parallel to entry 0
      send_word(CMD_CAST, 0, 300, -3, 200, -3);              // wall beyond the end point
      send_word(CMD_WRITE, 5, -4096, 0, 4095, 0);            // duplicate wall: tie
      send_word(CMD_WRITE, 700, -4096, -4096, 4095, 4095);
      send_word(CMD_CAST, 0, 4095, -4096, -4096, 4095);
      send_word(CMD_CAST, 0, -4096, 4095, 4095, -4096);
      send_word(CMD_WRITE, 6, 0, 0, 0, 50);                  // endpoint on the axis
      send_word(CMD_CAST, 0, -20, 0, 20, 0);
      send_word(CMD_CAST, 0, -7, 3, 9, -5);                  // truncation of negatives
      send_word(CMD_WRITE, 0, 0, 0, 0, 0);                   // erase walls
      send_word(CMD_WRITE, 5, 0, 0, 0, 0);
      send_word(CMD_CAST, 0, 0, -100, 0, 100);
      send_word(CMD_CAST, 1023, 4095, 4095, -4096, -4096);

      for (int n = 0; n < 520; n++) begin
         gaps_on = !(n >= 200 && n < 300);
         near = ($urandom_range(99) < 30);
         sel  = $urandom_range(99);
         if (sel < 15)
            send_word(CMD_CAST, $urandom_range(1023), pick_coord(near), pick_coord(near),
                      pick_coord(near), pick_coord(near));
         else if (sel < 25)
            send_word(CMD_WRITE, $urandom_range(1023), 0, 0, 0, 0);
         else
            send_word(CMD_WRITE, $urandom_range(1023), pick_coord(near), pick_coord(near),
                      pick_coord(near), pick_coord(near));
      end
      start <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
